FILE: rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/pli_pkg.sv
`default_nettype none
package pli_pkg;

	localparam int ANGLE_STEPS    = 256;
	localparam int DIST_FRAC_BITS = 4;
	localparam int ANGLE_W        = $clog2(ANGLE_STEPS);
	localparam int HALF_STEPS     = ANGLE_STEPS / 2;
	localparam int DIST_W         = 16;
	localparam int TRIG_W         = 17;
	localparam int Q_FRAC         = 15;
	localparam int X_SHIFT        = Q_FRAC - DIST_FRAC_BITS;
	localparam int PROD_W         = DIST_W + TRIG_W;
	localparam int NUM_W          = 46;
	localparam int DEN_W          = 36;
	localparam int QB             = 30;
	localparam int Q_W            = QB + 1;
	localparam int XM_W           = 24;
	localparam int OUT_W          = 16;
	localparam int FIFO_DEPTH     = 4;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint ONE_Q30 = 64'sd1 <<< 30;

	// Taylor term divisors (i-1)*i, indexed by the power i.
	localparam longint TAYLOR_DIV [20] = '{
		0, 0, 2, 6, 12, 20, 30, 42, 56, 72,
		90, 110, 132, 156, 182, 210, 240, 272, 306, 342
	};

	typedef logic signed [TRIG_W-1:0] trig_tab_t [ANGLE_STEPS];

	typedef struct packed {
		logic                     found;
		logic signed [DIST_W-1:0] rho;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [Q_W-1:0]    x;
	} pli_tag_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
		pli_tag_t                tag;
	} pli_fq_t;

	function automatic longint q15_round(input longint v);
		longint r;
		begin
			r = (v < 0) ? 64'sd0 : v;
			r = (r + (64'sd1 <<< 14)) >>> 15;
			if (r > 64'sd32768)
				r = 64'sd32768;
			return r;
		end
	endfunction

	// Build the sine or cosine table from truncated integer Taylor series.
	function automatic trig_tab_t gen_tab(input bit want_cos);
		trig_tab_t tab;
		longint    k, t, term, ssum, csum, v;
		bit        sneg, cneg;
		begin
			for (int idx = 0; idx < ANGLE_STEPS; idx++) begin
				k = longint'(idx);
				sneg = 1'b0;
				cneg = 1'b0;
				if (k >= ANGLE_STEPS) begin
					k = k - ANGLE_STEPS;
					sneg = 1'b1;
					cneg = 1'b1;
				end
				if (2 * k > ANGLE_STEPS) begin
					k = ANGLE_STEPS - k;
					cneg = !cneg;
				end
				t = (k * PI_Q30 + HALF_STEPS) >>> ANGLE_W;
				term = t;
				ssum = t;
				for (int i = 3; i <= 19; i += 2) begin
					term = (term * t) >>> 30;
					term = (term * t) >>> 30;
					term = term / TAYLOR_DIV[i];
					if ((((i - 1) >> 1) & 1) != 0)
						ssum = ssum - term;
					else
						ssum = ssum + term;
				end
				term = ONE_Q30;
				csum = ONE_Q30;
				for (int i = 2; i <= 18; i += 2) begin
					term = (term * t) >>> 30;
					term = (term * t) >>> 30;
					term = term / TAYLOR_DIV[i];
					if (((i >> 1) & 1) != 0)
						csum = csum - term;
					else
						csum = csum + term;
				end
				if (want_cos)
					v = cneg ? -q15_round(csum) : q15_round(csum);
				else
					v = sneg ? -q15_round(ssum) : q15_round(ssum);
				tab[idx] = TRIG_W'(v);
			end
			return tab;
		end
	endfunction

	localparam trig_tab_t SIN_TAB = gen_tab(1'b0);
	localparam trig_tab_t COS_TAB = gen_tab(1'b1);

endpackage
`default_nettype wire

FILE: rtl/core/pli_in_if.sv
`default_nettype none
interface pli_in_if;
	logic                                    valid;
	logic                                    ready;
	logic        [pli_pkg::ANGLE_W-1:0]      angle_one;
	logic signed [pli_pkg::DIST_W-1:0]       dist_one;
	logic        [pli_pkg::ANGLE_W-1:0]      angle_two;
	logic signed [pli_pkg::DIST_W-1:0]       dist_two;

	modport source (output valid, angle_one, dist_one, angle_two, dist_two, input ready);
	modport sink (input valid, angle_one, dist_one, angle_two, dist_two, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pli_out_if.sv
`default_nettype none
interface pli_out_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic signed [pli_pkg::OUT_W-1:0]  cross_x;
	logic signed [pli_pkg::OUT_W-1:0]  cross_y;
	logic                              clipped;

	modport source (output valid, found, cross_x, cross_y, clipped, input ready);
	modport sink (input valid, found, cross_x, cross_y, clipped, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/polar_line_intersection.sv
`default_nettype none
// Crossing point of two polar Hough lines. One word is taken per cycle and one
// result word leaves per cycle. A word passes through three front stages (trig
// table, products, determinant), a four-word queue, then two 32-stage
// bit-per-stage dividers in series (x, then y from the rounded x) with a multiply
// and a subtract stage between them, and a registered output. Throughput holds at
// one word per cycle while the output side takes words.
`include "assert_macros.svh"
module polar_line_intersection (
	input  wire logic clk,
	input  wire logic arst_n,
	pli_in_if.sink    line_in,
	pli_out_if.source cross_out
);

	logic             fq_valid, fq_ready;
	pli_pkg::pli_fq_t fq_data;
	logic             bq_valid, bq_ready;
	pli_pkg::pli_fq_t bq_data;

	pli_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.line_in (line_in),
		.fq_valid(fq_valid),
		.fq_data (fq_data),
		.fq_ready(fq_ready)
	);

	pli_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_data (fq_data),
		.push_ready(fq_ready),
		.pop_valid (bq_valid),
		.pop_data  (bq_data),
		.pop_ready (bq_ready)
	);

	pli_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_valid (bq_valid),
		.fq_data  (bq_data),
		.fq_ready (bq_ready),
		.cross_out(cross_out)
	);

	`ASSERT_CLK(a_nofind_zero, (cross_out.valid && !cross_out.found) |-> (cross_out.cross_x == '0 && cross_out.cross_y == '0 && !cross_out.clipped), "no-crossing word carries nonzero fields")
	`ASSERT_NEVER(a_clip_found, cross_out.valid && cross_out.clipped && !cross_out.found, "clipped set without a crossing")
	`ASSERT_CLK(a_queue_push, (fq_valid && !fq_ready) |=> fq_valid, "front dropped a word while the queue was full")

endmodule
`default_nettype wire

FILE: rtl/core/pli_front.sv
`default_nettype none
module pli_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pli_in_if.sink          line_in,
	output logic            fq_valid,
	output pli_pkg::pli_fq_t fq_data,
	input  wire logic       fq_ready
);

	logic en;
	logic v_s1, v_s2, v_s3;

	logic                                  eq_s1;
	logic signed [pli_pkg::DIST_W-1:0]     r1_s1, r2_s1;
	logic signed [pli_pkg::TRIG_W-1:0]     s1_s1, c1_s1, s2_s1, c2_s1;

	logic                                  eq_s2;
	logic signed [pli_pkg::DIST_W-1:0]     r1_s2, r2_s2;
	logic signed [pli_pkg::TRIG_W-1:0]     s1_s2, c1_s2, s2_s2, c2_s2;
	logic signed [pli_pkg::PROD_W-1:0]     r1s2_s2, r2s1_s2;
	logic signed [pli_pkg::PROD_W:0]       c1s2_s2, c2s1_s2;

	pli_pkg::pli_fq_t                      entry;
	pli_pkg::pli_fq_t                      entry_s3;
	logic signed [pli_pkg::PROD_W:0]       rdiff;
	logic signed [pli_pkg::DEN_W-1:0]      det;

	assign en = !v_s3 || fq_ready;
	assign line_in.ready = en;
	assign fq_valid = v_s3;
	assign fq_data = entry_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= line_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eq_s1 <= line_in.angle_one == line_in.angle_two;
			r1_s1 <= line_in.dist_one;
			r2_s1 <= line_in.dist_two;
			s1_s1 <= pli_pkg::SIN_TAB[line_in.angle_one];
			c1_s1 <= pli_pkg::COS_TAB[line_in.angle_one];
			s2_s1 <= pli_pkg::SIN_TAB[line_in.angle_two];
			c2_s1 <= pli_pkg::COS_TAB[line_in.angle_two];

			eq_s2   <= eq_s1;
			r1_s2   <= r1_s1;
			r2_s2   <= r2_s1;
			s1_s2   <= s1_s1;
			c1_s2   <= c1_s1;
			s2_s2   <= s2_s1;
			c2_s2   <= c2_s1;
			r1s2_s2 <= r1_s1 * s2_s1;
			r2s1_s2 <= r2_s1 * s1_s1;
			c1s2_s2 <= c1_s1 * s2_s1;
			c2s1_s2 <= c2_s1 * s1_s1;

			entry_s3 <= entry;
		end
	end

	// Pick the divide for x and the line that later gives y.
	always_comb begin
		rdiff = r1s2_s2 - r2s1_s2;
		det   = pli_pkg::DEN_W'(c1s2_s2) - pli_pkg::DEN_W'(c2s1_s2);
		entry.tag.found = !eq_s2 && (det != '0);
		entry.tag.x     = '0;
		if (s1_s2 == '0) begin
			entry.num       = pli_pkg::NUM_W'(r1_s2) <<< pli_pkg::Q_FRAC;
			entry.den       = pli_pkg::DEN_W'(c1_s2) <<< pli_pkg::DIST_FRAC_BITS;
			entry.tag.rho   = r2_s2;
			entry.tag.cos_v = c2_s2;
			entry.tag.sin_v = s2_s2;
		end else if (s2_s2 == '0) begin
			entry.num       = pli_pkg::NUM_W'(r2_s2) <<< pli_pkg::Q_FRAC;
			entry.den       = pli_pkg::DEN_W'(c2_s2) <<< pli_pkg::DIST_FRAC_BITS;
			entry.tag.rho   = r1_s2;
			entry.tag.cos_v = c1_s2;
			entry.tag.sin_v = s1_s2;
		end else begin
			entry.num       = pli_pkg::NUM_W'(rdiff) <<< pli_pkg::X_SHIFT;
			entry.den       = det;
			entry.tag.rho   = r1_s2;
			entry.tag.cos_v = c1_s2;
			entry.tag.sin_v = s1_s2;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/pli_queue.sv
`default_nettype none
module pli_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	input  pli_pkg::pli_fq_t push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output pli_pkg::pli_fq_t pop_data,
	input  wire logic        pop_ready
);

	localparam int PW = $clog2(pli_pkg::FIFO_DEPTH);

	pli_pkg::pli_fq_t mem [pli_pkg::FIFO_DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != PW'(0) + (PW+1)'(pli_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

FILE: rtl/core/pli_div.sv
`default_nettype none
module pli_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic signed [pli_pkg::NUM_W-1:0] num,
	input  wire logic signed [pli_pkg::DEN_W-1:0] den,
	input  pli_pkg::pli_tag_t                 in_tag,
	output logic                              out_valid,
	output logic signed [pli_pkg::Q_W-1:0]    quo,
	output pli_pkg::pli_tag_t                 out_tag
);

	localparam int QB = pli_pkg::QB;
	localparam int MW = pli_pkg::NUM_W - 1;
	localparam int DW = pli_pkg::DEN_W - 1;
	localparam int CW = DW + QB;

	logic              v_s   [QB+1];
	logic [MW-1:0]     rem_s [QB+1];
	logic [DW-1:0]     dm_s  [QB+1];
	logic [QB-1:0]     q_s   [QB+1];
	logic              neg_s [QB+1];
	pli_pkg::pli_tag_t tag_s [QB+1];

	logic [pli_pkg::NUM_W-1:0] num_abs;
	logic [pli_pkg::DEN_W-1:0] den_abs;
	logic [MW:0]               two_r;
	logic                      inc;
	logic [QB:0]               mag;

	assign num_abs = num[pli_pkg::NUM_W-1] ? -num : num;
	assign den_abs = den[pli_pkg::DEN_W-1] ? -den : den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_abs[MW-1:0];
			dm_s[0]  <= den_abs[DW-1:0];
			q_s[0]   <= '0;
			neg_s[0] <= num[pli_pkg::NUM_W-1] ^ den[pli_pkg::DEN_W-1];
			tag_s[0] <= in_tag;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [CW-1:0] trial;
		logic [CW-1:0] remx;
		logic          ge;

		assign trial = CW'(dm_s[i]) << (QB - 1 - i);
		assign remx  = CW'(rem_s[i]);
		assign ge    = remx >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? MW'(remx - trial) : rem_s[i];
				dm_s[i+1]  <= dm_s[i];
				q_s[i+1]   <= q_s[i] | (QB'(ge) << (QB - 1 - i));
				neg_s[i+1] <= neg_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	// Round to nearest, ties to even, on the magnitude.
	assign two_r = {rem_s[QB], 1'b0};
	assign inc   = (two_r > (MW+1)'(dm_s[QB])) ||
	               ((two_r == (MW+1)'(dm_s[QB])) && q_s[QB][0]);
	assign mag   = (QB+1)'(q_s[QB]) + (QB+1)'(inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_s[QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo     <= neg_s[QB] ? -$signed(mag) : $signed(mag);
			out_tag <= tag_s[QB];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/pli_back.sv
`default_nettype none
module pli_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fq_valid,
	input  pli_pkg::pli_fq_t fq_data,
	output logic             fq_ready,
	pli_out_if.source        cross_out
);

	localparam int MUL_W = pli_pkg::XM_W + pli_pkg::TRIG_W;

	logic en;

	logic                              xv;
	logic signed [pli_pkg::Q_W-1:0]    xq;
	pli_pkg::pli_tag_t                 xtag;
	pli_pkg::pli_tag_t                 xtag_x;

	logic                              v_s1, v_s2;
	pli_pkg::pli_tag_t                 tag_s1, tag_s2;
	logic signed [MUL_W-1:0]           prod_s1;
	logic signed [pli_pkg::NUM_W-1:0]  ny_s2;
	logic signed [pli_pkg::DEN_W-1:0]  dy_s2;

	logic                              yv;
	logic signed [pli_pkg::Q_W-1:0]    yq;
	pli_pkg::pli_tag_t                 ytag;

	localparam logic signed [pli_pkg::Q_W-1:0] SAT_MAX = pli_pkg::Q_W'(32767);
	localparam logic signed [pli_pkg::Q_W-1:0] SAT_MIN = -pli_pkg::Q_W'(32768);

	logic x_hi, x_lo, y_hi, y_lo;

	assign en       = !cross_out.valid || cross_out.ready;
	assign fq_ready = en;

	pli_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fq_valid),
		.num      (fq_data.num),
		.den      (fq_data.den),
		.in_tag   (fq_data.tag),
		.out_valid(xv),
		.quo      (xq),
		.out_tag  (xtag)
	);

	// Carry the rounded x along with the line that gives y.
	always_comb begin
		xtag_x   = xtag;
		xtag_x.x = xq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= xv;
			v_s2 <= v_s1;
		end
	end

	// x stays well inside XM_W bits for any pair that crosses.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= pli_pkg::XM_W'(xq) * xtag.cos_v;
			tag_s1  <= xtag_x;

			ny_s2  <= (pli_pkg::NUM_W'(tag_s1.rho) <<< pli_pkg::X_SHIFT) -
			          pli_pkg::NUM_W'(prod_s1);
			dy_s2  <= pli_pkg::DEN_W'(tag_s1.sin_v);
			tag_s2 <= tag_s1;
		end
	end

	pli_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      (ny_s2),
		.den      (dy_s2),
		.in_tag   (tag_s2),
		.out_valid(yv),
		.quo      (yq),
		.out_tag  (ytag)
	);

	assign x_hi = ytag.x > SAT_MAX;
	assign x_lo = ytag.x < SAT_MIN;
	assign y_hi = yq > SAT_MAX;
	assign y_lo = yq < SAT_MIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cross_out.valid <= 1'b0;
		else if (en)
			cross_out.valid <= yv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_out.found <= ytag.found;
			if (!ytag.found) begin
				cross_out.cross_x <= '0;
				cross_out.cross_y <= '0;
				cross_out.clipped <= 1'b0;
			end else begin
				cross_out.cross_x <= x_hi ? pli_pkg::OUT_W'(SAT_MAX) :
				                     x_lo ? pli_pkg::OUT_W'(SAT_MIN) :
				                     pli_pkg::OUT_W'(ytag.x);
				cross_out.cross_y <= y_hi ? pli_pkg::OUT_W'(SAT_MAX) :
				                     y_lo ? pli_pkg::OUT_W'(SAT_MIN) :
				                     pli_pkg::OUT_W'(yq);
				cross_out.clipped <= x_hi || x_lo || y_hi || y_lo;
			end
		end
	end

endmodule
`default_nettype wire
